// ----- rtl/rgbconv_pkg.sv -----
// Package for the RGB image convolution unit.
// Holds the sequencer states, line store control types, register codes and kernel helpers.
// No dependencies.
package rgbconv_pkg;

    // Number of line store banks: three held rows plus the row being received.
    localparam int NBANK    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_SIZE  = 3'd2,
        CFG_CENTER_X     = 3'd3,
        CFG_CENTER_Y     = 3'd4,
        CFG_KROW_ZERO    = 3'd5,
        CFG_KROW_ONE     = 3'd6,
        CFG_KROW_TWO     = 3'd7
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_TAP,
        ST_DRAIN,
        ST_PLANT,
        ST_DIVW,
        ST_OUT,
        ST_ROWEND,
        ST_COPY,
        ST_COPYEND
    } state_t;

    // Source of the data written into a line store bank.
    typedef enum logic [2:0] {
        LSRC_ZERO,
        LSRC_PIXEL,
        LSRC_BANK0,
        LSRC_BANK1,
        LSRC_BANK2,
        LSRC_BANK3
    } line_src_t;

    // Write control of the line store, one enable and one source per bank.
    typedef struct packed {
        logic [NBANK-1:0]      we;
        line_src_t [NBANK-1:0] src;
    } lines_ctl_t;

    // Bank index to write source.
    function automatic line_src_t bank_src(input logic [1:0] idx);
        line_src_t s;
        case (idx)
            2'd0:    s = LSRC_BANK0;
            2'd1:    s = LSRC_BANK1;
            2'd2:    s = LSRC_BANK2;
            default: s = LSRC_BANK3;
        endcase
        return s;
    endfunction

    // Signed coefficient of kernel row ky, column kx.
    function automatic logic signed [7:0] coef(input logic [2:0][23:0] rows,
                                               input logic [1:0] ky,
                                               input logic [1:0] kx);
        logic [23:0] r;
        logic [7:0]  c;
        r = (ky == 2'd1) ? rows[1] : ((ky == 2'd2) ? rows[2] : rows[0]);
        c = (kx == 2'd1) ? r[15:8] : ((kx == 2'd2) ? r[23:16] : r[7:0]);
        return $signed(c);
    endfunction

    // Sum of the active k x k coefficients, sign extended to 16 bits.
    function automatic logic [15:0] kernel_div(input logic [2:0][23:0] rows,
                                               input logic [1:0] k);
        logic [15:0] s;
        logic [7:0]  c;
        s = '0;
        for (int ky = 0; ky < 3; ky++) begin
            for (int kx = 0; kx < 3; kx++) begin
                c = coef(rows, 2'(ky), 2'(kx));
                if (2'(ky) < k && 2'(kx) < k) begin
                    s = s + {{8{c[7]}}, c};
                end
            end
        end
        return s;
    endfunction

    // Line store slot that holds kernel row ky, given the number of held rows.
    function automatic logic [1:0] ls_slot(input logic [1:0] rb,
                                           input logic [1:0] ky,
                                           input logic [1:0] k);
        logic [3:0] v;
        v = 4'(rb) + 4'(ky) + 4'd3 - 4'(k - 2'd1);
        if (v >= 4'd6) begin
            v = v - 4'd6;
        end else if (v >= 4'd3) begin
            v = v - 4'd3;
        end
        return v[1:0];
    endfunction

endpackage

// ----- rtl/rgbconv_if.sv -----
// Stream interfaces of the RGB image convolution unit: input pixel and result pixel.
// Valid/ready handshake; a word moves when both are high. No dependencies.
interface rgbconv_pixel_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, op, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, red_in, green_in, blue_in, output ready);
endinterface

interface rgbconv_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [8:0] out_column;
    logic       row_end;

    modport source (output valid, red_out, green_out, blue_out, out_column, row_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_column, row_end,
                    output ready);
endinterface

// ----- rtl/rgbconv_lines.sv -----
// Line store of the convolution unit: three held rows and the current row.
// Each bank has one write and one registered read port. Depends on rgbconv_pkg.
module rgbconv_lines #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                                 clk,
    input  rgbconv_pkg::lines_ctl_t              ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
    input  logic [23:0]                          pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output logic [rgbconv_pkg::NBANK-1:0][23:0]  rd_data
);
    import rgbconv_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [NBANK-1:0][23:0] wr_data;

    // Write data per bank: zero, the incoming pixel, or a word read from a bank.
    always_comb
    begin
        for (int b = 0; b < NBANK; b++) begin
            case (ctl.src[b])
                LSRC_ZERO:  wr_data[b] = '0;
                LSRC_PIXEL: wr_data[b] = pixel;
                LSRC_BANK0: wr_data[b] = rd_data[0];
                LSRC_BANK1: wr_data[b] = rd_data[1];
                LSRC_BANK2: wr_data[b] = rd_data[2];
                LSRC_BANK3: wr_data[b] = rd_data[3];
                default:    wr_data[b] = '0;
            endcase
        end
    end

    // One memory per bank, all read at the same address.
    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        logic [23:0] mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (ctl.we[g]) begin
                mem[wr_addr] <= wr_data[g];
            end
            rd_data[g] <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/rgbconv_div.sv -----
// Restoring divider of the convolution unit, one quotient bit per cycle.
// Unsigned 16-bit operands; done pulses for one cycle. Depends on nothing.
module rgbconv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] rem_sh;

    // One shift and subtract step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[15:0], quo_reg[15]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/rgb_image_convolution_unit.sv -----
// Top level of the RGB image convolution unit: sequencer, tap multiply-accumulate
// and output register. Depends on rgbconv_pkg, rgbconv_if, rgbconv_lines, rgbconv_div.
//
//  Port      | Kind          | Word
//  ----------+---------------+----------------------------------------------
//  pixel     | stream in     | op, red_in, green_in, blue_in
//  result    | stream out    | red_out, green_out, blue_out, out_column, row_end
//  cfg_*     | register write| cfg_write, cfg_index, cfg_data
//
// After reset a clearing pass zeroes the line store; pixel.ready is low meanwhile.
// Each result passes through the shared tap multiply-accumulate and, for each channel
// that is neither clamped nor has a zero divisor, through the shared divider.
// A row end that moves rows adds a line store copy (one column per cycle).
// A stalled result holds the sequencer in its output state until result.ready.
module rgb_image_convolution_unit #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    rgbconv_pixel_if.sink                          pixel,
    rgbconv_result_if.source                       result,
    input  logic                                   cfg_write,
    input  logic [rgbconv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbconv_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rgbconv_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 10) ? CW + 1 : 10;
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

    // Configuration registers.
    logic [9:0]        width_reg, height_reg;
    logic [1:0]        ksize_reg, cx_reg, cy_reg;
    logic [2:0][23:0]  krow_reg;

    // Sequencer and frame state.
    state_t            state_reg, state_next;
    logic              started_reg, started_next;
    logic [1:0]        rb_reg, rb_next;
    logic [CW:0]       cc_reg, cc_next;
    logic [9:0]        rows_reg, rows_next;
    logic [CW:0]       ec_reg, ec_next;
    logic [CW-1:0]     col_reg, col_next;
    logic              last_reg, last_next;
    logic              full_reg, full_next;
    logic [1:0]        lag_reg, lag_next;
    logic              op_reg, op_next;
    logic [1:0]        n_reg, n_next;
    logic [1:0]        ky_reg, ky_next, kx_reg, kx_next;
    logic              drain_reg, drain_next;
    logic [1:0]        ch_reg, ch_next;
    logic [CW-1:0]     sweep_reg, sweep_next, sweep_d_reg, sweep_d_next;
    logic              copy_pend_reg, copy_pend_next;
    logic [NBANK-1:0]  copy_we_reg, copy_we_next;
    line_src_t [NBANK-1:0] copy_src_reg, copy_src_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [2:0][15:0]  acc_reg, acc_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_coef_reg, s1_coef_next;
    logic [1:0]        s1_sel_reg, s1_sel_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [2:0][15:0]  s2_prod_reg, s2_prod_next;
    logic [15:0]       div_reg, div_next;
    logic [2:0][7:0]   res_reg, res_next;
    logic [7:0]        out_r_reg, out_r_next, out_g_reg, out_g_next, out_b_reg, out_b_next;
    logic [8:0]        out_col_reg, out_col_next;
    logic              out_end_reg, out_end_next;

    // Derived values.
    logic [1:0]        k_eff;
    logic [CW:0]       w_eff, wm1;
    logic [1:0]        rb_start, rb_use;
    logic [CW-1:0]     col_in;
    logic              accept, ignore, emit_ok, out_free;
    logic [CW+1:0]     tap_p, tap_pos;
    logic              tap_inside, tap_last;
    logic [1:0]        tap_sel;
    logic signed [15:0] s_val, top_val, div_s;
    logic              need_div;
    logic [7:0]        plant_val, q_byte;
    logic [15:0]       div_mag;
    logic [NBANK-1:0]  plan_we;
    line_src_t [NBANK-1:0] plan_src;
    logic [1:0]        plan_j;
    logic [23:0]       pix_word;
    logic signed [17:0] prod_full [3];

    // Shared unit connections.
    lines_ctl_t               lines_ctl;
    logic [CW-1:0]            wr_addr, rd_addr;
    logic [NBANK-1:0][23:0]   rd_data;
    logic                     div_start, div_done;
    logic [15:0]              div_q;

    rgbconv_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
        .clk     (clk),
        .ctl     (lines_ctl),
        .wr_addr (wr_addr),
        .pixel   (pix_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rgbconv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg[ch_reg]),
        .divisor  (div_mag),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= 10'd352;
            height_reg <= 10'd288;
            ksize_reg  <= 2'd3;
            cx_reg     <= 2'd1;
            cy_reg     <= 2'd1;
            krow_reg   <= {3{24'd65793}};
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg   <= cfg_data[9:0];
                CFG_IMAGE_HEIGHT: height_reg  <= cfg_data[9:0];
                CFG_KERNEL_SIZE:  ksize_reg   <= cfg_data[1:0];
                CFG_CENTER_X:     cx_reg      <= cfg_data[1:0];
                CFG_CENTER_Y:     cy_reg      <= cfg_data[1:0];
                CFG_KROW_ZERO:    krow_reg[0] <= cfg_data;
                CFG_KROW_ONE:     krow_reg[1] <= cfg_data;
                CFG_KROW_TWO:     krow_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective geometry and per-word decisions.
    always_comb
    begin
        k_eff    = (ksize_reg == 2'd0) ? 2'd1 : ksize_reg;
        if (width_reg == 10'd0) begin
            w_eff = (CW+1)'(1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(width_reg);
        end
        wm1      = w_eff - (CW+1)'(1);
        rb_start = (cy_reg < k_eff - 2'd1) ? cy_reg : k_eff - 2'd1;
        rb_use   = started_reg ? rb_reg : rb_start;
        col_in   = (cc_reg < w_eff) ? cc_reg[CW-1:0] : wm1[CW-1:0];
        accept   = pixel.valid && pixel.ready;
        ignore   = pixel.op && (rows_reg < height_reg);
        pix_word = pixel.op ? 24'd0 : {pixel.blue_in, pixel.green_in, pixel.red_in};
        emit_ok  = full_reg && (n_reg != 2'd3) && (ec_reg < w_eff)
                   && (last_reg || ((CW+2)'(ec_reg) + (CW+2)'(lag_reg)
                                    <= (CW+2)'(col_reg)));
        out_free = !out_valid_reg || result.ready;

        // Tap address and bank for the current kernel position.
        tap_p      = (CW+2)'(ec_reg) + (CW+2)'(kx_reg);
        tap_pos    = tap_p - (CW+2)'(cx_reg);
        tap_inside = (tap_p >= (CW+2)'(cx_reg)) && (tap_pos < (CW+2)'(w_eff));
        tap_sel    = (ky_reg == k_eff - 2'd1) ? 2'd3 : ls_slot(rb_reg, ky_reg, k_eff);
        tap_last   = (ky_reg == k_eff - 2'd1) && (kx_reg == k_eff - 2'd1);

        // Saturation and divider operands of one channel.
        s_val     = $signed(acc_reg[ch_reg]);
        div_s     = $signed(div_reg);
        top_val   = $signed(16'(div_reg << 8) - div_reg);
        need_div  = !(s_val > top_val) && !(s_val < 16'sd0) && (div_reg != 16'd0);
        if (s_val > top_val) begin
            plant_val = 8'd255;
        end else if (s_val < 16'sd0) begin
            plant_val = 8'd0;
        end else begin
            plant_val = 8'(acc_reg[ch_reg] + 16'd128);
        end
        div_mag = div_s[15] ? (~div_reg + 16'd1) : div_reg;
        q_byte  = div_s[15] ? 8'(~div_q + 16'd1) : div_q[7:0];

        // Row end: which banks take which row. With k = 3 and a full store, kernel row 1 moves up to row 0.
        plan_we  = '0;
        plan_src = {NBANK{LSRC_ZERO}};
        plan_j   = ls_slot(rb_reg, 2'd1, k_eff);
        if (full_reg) begin
            if (k_eff != 2'd1) begin
                if (k_eff == 2'd3 && plan_j != 2'd0) begin
                    plan_we[0]  = 1'b1;
                    plan_src[0] = bank_src(plan_j);
                end
                plan_we[k_eff - 2'd2]  = 1'b1;
                plan_src[k_eff - 2'd2] = LSRC_BANK3;
            end
        end else begin
            plan_we[rb_reg]  = 1'b1;
            plan_src[rb_reg] = LSRC_BANK3;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (sweep_reg == LAST_COL) state_next = ST_IDLE;
            ST_IDLE:    if (accept && !ignore) state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (emit_ok) begin
                    state_next = ST_TAP;
                end else if (last_reg) begin
                    state_next = ST_ROWEND;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAP:     if (tap_last) state_next = ST_DRAIN;
            ST_DRAIN:   if (!drain_reg) state_next = ST_PLANT;
            ST_PLANT:
            begin
                if (need_div) begin
                    state_next = ST_DIVW;
                end else if (ch_reg == 2'd2) begin
                    state_next = ST_OUT;
                end
            end
            ST_DIVW:    if (div_done) state_next = (ch_reg == 2'd2) ? ST_OUT : ST_PLANT;
            ST_OUT:     if (out_free) state_next = ST_EVAL;
            ST_ROWEND:  state_next = (|plan_we) ? ST_COPY : ST_IDLE;
            ST_COPY:    if (sweep_reg == LAST_COL) state_next = ST_COPYEND;
            ST_COPYEND: state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Outputs: handshakes, line store control, divider start.
    always_comb
    begin
        pixel.ready       = (state_reg == ST_IDLE);
        result.valid      = out_valid_reg;
        result.red_out    = out_r_reg;
        result.green_out  = out_g_reg;
        result.blue_out   = out_b_reg;
        result.out_column = out_col_reg;
        result.row_end    = out_end_reg;
        div_start         = (state_reg == ST_PLANT) && need_div;
        lines_ctl.we      = '0;
        lines_ctl.src     = {NBANK{LSRC_ZERO}};
        wr_addr           = sweep_d_reg;
        rd_addr           = (state_reg == ST_TAP) ? tap_pos[CW-1:0] : sweep_reg;
        if (state_reg == ST_CLEAR) begin
            lines_ctl.we = '1;
            wr_addr      = sweep_reg;
        end else if (state_reg == ST_IDLE && accept && !ignore) begin
            lines_ctl.we[3]  = 1'b1;
            lines_ctl.src[3] = LSRC_PIXEL;
            wr_addr          = col_in;
        end else if (copy_pend_reg) begin
            lines_ctl.we  = copy_we_reg;
            lines_ctl.src = copy_src_reg;
        end
    end

    // Next values of the sequencer counters and the datapath.
    always_comb
    begin
        started_next   = started_reg;
        rb_next        = rb_reg;
        cc_next        = cc_reg;
        rows_next      = rows_reg;
        ec_next        = ec_reg;
        col_next       = col_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        lag_next       = lag_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        ky_next        = ky_reg;
        kx_next        = kx_reg;
        drain_next     = drain_reg;
        ch_next        = ch_reg;
        sweep_next     = sweep_reg;
        copy_we_next   = copy_we_reg;
        copy_src_next  = copy_src_reg;
        acc_next       = acc_reg;
        div_next       = div_reg;
        res_next       = res_reg;
        out_r_next     = out_r_reg;
        out_g_next     = out_g_reg;
        out_b_next     = out_b_reg;
        out_col_next   = out_col_reg;
        out_end_next   = out_end_reg;
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:   sweep_next = sweep_reg + CW'(1);
            ST_IDLE:
            begin
                if (accept && !ignore) begin
                    started_next = 1'b1;
                    rb_next      = rb_use;
                    col_next     = col_in;
                    last_next    = (CW+1)'(col_in) == wm1;
                    full_next    = rb_use >= k_eff - 2'd1;
                    lag_next     = (k_eff - 2'd1 > cx_reg) ? k_eff - 2'd1 - cx_reg : 2'd0;
                    op_next      = pixel.op;
                    n_next       = 2'd0;
                end
            end
            ST_EVAL:
            begin
                if (emit_ok) begin
                    ky_next  = 2'd0;
                    kx_next  = 2'd0;
                    acc_next = '0;
                    div_next = kernel_div(krow_reg, k_eff);
                end else if (!last_reg) begin
                    cc_next = (CW+1)'(col_reg) + (CW+1)'(1);
                end
            end
            ST_TAP:
            begin
                if (kx_reg == k_eff - 2'd1) begin
                    kx_next = 2'd0;
                    ky_next = ky_reg + 2'd1;
                end else begin
                    kx_next = kx_reg + 2'd1;
                end
                drain_next = 1'b1;
            end
            ST_DRAIN:   drain_next = 1'b0;
            ST_PLANT:
            begin
                if (!need_div) begin
                    res_next[ch_reg] = plant_val;
                    ch_next          = (ch_reg == 2'd2) ? 2'd0 : ch_reg + 2'd1;
                end
            end
            ST_DIVW:
            begin
                if (div_done) begin
                    res_next[ch_reg] = q_byte;
                    ch_next          = (ch_reg == 2'd2) ? 2'd0 : ch_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_r_next     = res_reg[0];
                    out_g_next     = res_reg[1];
                    out_b_next     = res_reg[2];
                    out_col_next   = 9'(ec_reg);
                    out_end_next   = (ec_reg == wm1);
                    ec_next        = ec_reg + (CW+1)'(1);
                    n_next         = n_reg + 2'd1;
                end
            end
            ST_ROWEND:
            begin
                copy_we_next  = plan_we;
                copy_src_next = plan_src;
                rb_next       = full_reg ? k_eff - 2'd1 : rb_reg + 2'd1;
                ec_next       = '0;
                cc_next       = '0;
                sweep_next    = '0;
                if (!op_reg && rows_reg != 10'd1023) begin
                    rows_next = rows_reg + 10'd1;
                end
            end
            ST_COPY:    sweep_next = sweep_reg + CW'(1);
            default:    ;
        endcase

        // Tap pipeline: address, then product, then accumulate.
        s1_valid_next = (state_reg == ST_TAP) && tap_inside;
        s1_coef_next  = coef(krow_reg, ky_reg, kx_reg);
        s1_sel_next   = tap_sel;
        s2_valid_next = s1_valid_reg;
        for (int c = 0; c < 3; c++) begin
            prod_full[c]    = $signed({1'b0, rd_data[s1_sel_reg][8*c +: 8]})
                              * $signed({s1_coef_reg[7], s1_coef_reg});
            s2_prod_next[c] = prod_full[c][15:0];
            if (s2_valid_reg) begin
                acc_next[c] = acc_reg[c] + s2_prod_reg[c];
            end
        end

        copy_pend_next = (state_reg == ST_COPY);
        sweep_d_next   = sweep_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            started_reg   <= 1'b0;
            rb_reg        <= '0;
            cc_reg        <= '0;
            rows_reg      <= '0;
            ec_reg        <= '0;
            n_reg         <= '0;
            ky_reg        <= '0;
            kx_reg        <= '0;
            drain_reg     <= 1'b0;
            ch_reg        <= '0;
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            rb_reg        <= rb_next;
            cc_reg        <= cc_next;
            rows_reg      <= rows_next;
            ec_reg        <= ec_next;
            n_reg         <= n_next;
            ky_reg        <= ky_next;
            kx_reg        <= kx_next;
            drain_reg     <= drain_next;
            ch_reg        <= ch_next;
            sweep_reg     <= sweep_next;
            copy_pend_reg <= copy_pend_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        last_reg     <= last_next;
        full_reg     <= full_next;
        lag_reg      <= lag_next;
        op_reg       <= op_next;
        sweep_d_reg  <= sweep_d_next;
        copy_we_reg  <= copy_we_next;
        copy_src_reg <= copy_src_next;
        acc_reg      <= acc_next;
        s1_coef_reg  <= s1_coef_next;
        s1_sel_reg   <= s1_sel_next;
        s2_prod_reg  <= s2_prod_next;
        div_reg      <= div_next;
        res_reg      <= res_next;
        out_r_reg    <= out_r_next;
        out_g_reg    <= out_g_next;
        out_b_reg    <= out_b_next;
        out_col_reg  <= out_col_next;
        out_end_reg  <= out_end_next;
    end

    // A new result word only comes from the output state.
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result word loaded outside the output state");

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_reg != 16'd0)
        else $error("divider started with zero divisor");

    // Taps are only walked once enough rows are held.
    a_tap_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAP) |-> full_reg)
        else $error("convolution started without full line store");

    // A row end restarts the column counters.
    a_rowend_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWEND) |=> (ec_reg == '0 && cc_reg == '0))
        else $error("column counters not cleared at row end");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for rgb_image_convolution_unit.
// Drives pixel words in raster order and checks every result against a built-in predictor.
// Depends on rgbconv_pkg, rgbconv_if and the unit's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbconv_pkg::*;

    localparam int LINE_MAX = 512;
    localparam int SETTLE_CYCLES = 1500;

    typedef struct {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] column;
        logic       row_end;
    } filtered_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgbconv_pixel_if  pix ();
    rgbconv_result_if res ();

    rgb_image_convolution_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix),
        .result    (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers.
    logic [9:0]  img_w;
    logic [9:0]  img_h;
    logic [1:0]  ksize;
    logic [1:0]  anchor_x;
    logic [1:0]  anchor_y;
    logic [23:0] krow [3];

    // Predictor copy of the line buffering state.
    logic [23:0] held_rows [3][LINE_MAX];
    logic [23:0] live_row [LINE_MAX];
    int          col_count;
    int          rows_done;
    int          rows_held;
    int          next_emit;
    bit          frame_started;

    pixel_word_t pending_words [$];
    filtered_t   filtered_due [$];

    int errors;
    int words_queued;
    int words_taken;
    int results_seen;
    int settings_used;

    // Sender and receiver pacing.
    int  burst_left;
    int  gap_left;
    bit  gaps_on;
    int  stall_mode;
    int  stall_left;

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic int coef_at(int ky, int kx);
        logic [7:0] c;
        c = krow[ky][8*kx +: 8];
        return $signed(c);
    endfunction

    function automatic int to_s16(int x);
        logic [15:0] u;
        u = x[15:0];
        return $signed(u);
    endfunction

    function automatic logic [7:0] clamp_channel(int s, int dv, int top);
        int q;
        if (s > top) return 8'd255;
        if (s < 0) return 8'd0;
        if (dv == 0) return 8'(s + 128);
        q = s / dv;
        return q[7:0];
    endfunction

    function automatic logic [23:0] filter_at(int o, int k, int w);
        logic [15:0] acc [3];
        logic [23:0] tap;
        logic [23:0] outp;
        int dv;
        int top;
        int p;
        int c;
        int v;
        int slot;
        dv = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = '0;
        end
        for (int ky = 0; ky < k; ky++)
        begin
            for (int kx = 0; kx < k; kx++)
            begin
                dv += coef_at(ky, kx);
            end
        end
        dv = to_s16(dv);
        top = to_s16(255 * dv);
        for (int ky = 0; ky < k; ky++)
        begin
            slot = (rows_held + ky - (k - 1)) % 3;
            for (int kx = 0; kx < k; kx++)
            begin
                p = o + kx;
                c = coef_at(ky, kx);
                if (p < anchor_x || p - anchor_x >= w)
                begin
                    continue;
                end
                tap = (ky == k - 1) ? live_row[p - anchor_x] : held_rows[slot][p - anchor_x];
                for (int ch = 0; ch < 3; ch++)
                begin
                    v = tap[8*ch +: 8];
                    acc[ch] = acc[ch] + 16'(v * c);
                end
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            outp[8*ch +: 8] = clamp_channel($signed(acc[ch]), dv, top);
        end
        return outp;
    endfunction

    // Move the finished row into the held rows.
    task automatic shift_rows(int k, bit full);
        int src;
        if (full)
        begin
            if (k == 1)
            begin
                rows_held = 0;
                return;
            end
            for (int i = 0; i + 2 < k; i++)
            begin
                src = (rows_held + i - (k - 2)) % 3;
                for (int x = 0; x < LINE_MAX; x++)
                begin
                    held_rows[i][x] = held_rows[src][x];
                end
            end
            for (int x = 0; x < LINE_MAX; x++)
            begin
                held_rows[k - 2][x] = live_row[x];
            end
            rows_held = k - 1;
        end
        else
        begin
            for (int x = 0; x < LINE_MAX; x++)
            begin
                held_rows[rows_held % 3][x] = live_row[x];
            end
            rows_held++;
        end
    endtask

    // Work out the filtered pixels that one accepted word releases.
    task automatic predict_word(pixel_word_t wd);
        int k;
        int w;
        int col;
        int lag;
        int n;
        bit full;
        bit last;
        logic [23:0] px;
        filtered_t f;
        k = (ksize == 0) ? 1 : int'(ksize);
        w = (img_w == 0) ? 1 : ((img_w > LINE_MAX) ? LINE_MAX : int'(img_w));
        if (wd.op && rows_done < img_h)
        begin
            return;
        end
        if (!frame_started)
        begin
            rows_held = (anchor_y < k - 1) ? int'(anchor_y) : k - 1;
            frame_started = 1;
        end
        col = (col_count < w) ? col_count : w - 1;
        live_row[col] = wd.op ? 24'd0 : {wd.blue, wd.green, wd.red};
        full = rows_held >= k - 1;
        last = (col == w - 1);
        lag = (k - 1 > anchor_x) ? (k - 1 - anchor_x) : 0;
        n = 0;
        if (full)
        begin
            while (n < 3 && next_emit < w && (last || next_emit + lag <= col))
            begin
                px = filter_at(next_emit, k, w);
                f.red = px[7:0];
                f.green = px[15:8];
                f.blue = px[23:16];
                f.column = 9'(next_emit);
                f.row_end = (next_emit == w - 1);
                filtered_due.push_back(f);
                next_emit++;
                n++;
            end
        end
        if (last)
        begin
            shift_rows(k, full);
            next_emit = 0;
            col_count = 0;
            if (!wd.op && rows_done < 1023)
            begin
                rows_done++;
            end
        end
        else
        begin
            col_count = col + 1;
        end
    endtask

    // ---------------------------------------------------------------- driver and monitor

    // Sender: bursts of words separated by random gaps when gaps_on is set.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix.valid <= 1'b0;
        end
        else if (!pix.valid || pix.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                pix.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                pix.op <= pending_words[0].op;
                pix.red_in <= pending_words[0].red;
                pix.green_in <= pending_words[0].green;
                pix.blue_in <= pending_words[0].blue;
                pix.valid <= 1'b1;
                void'(pending_words.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= gaps_on ? $urandom_range(0, 6) : 0;
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                pix.valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls or long stall stretches, depending on the mode.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= 1'b1;
            if (stall_mode == 1 && $urandom_range(0, 99) < 40)
            begin
                stall_left <= 1;
            end
            else if (stall_mode == 2 && $urandom_range(0, 99) < 8)
            begin
                stall_left <= $urandom_range(5, 30);
            end
        end
    end

    // Monitor: predict on each accepted pixel word, check each accepted result word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix.valid && pix.ready)
            begin
                predict_word('{pix.op, pix.red_in, pix.green_in, pix.blue_in});
                words_taken++;
            end
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (filtered_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result rgb=%h/%h/%h col=%0d end=%b", $time,
                             res.red_out, res.green_out, res.blue_out, res.out_column,
                             res.row_end);
                end
                else
                begin
                    if (res.red_out !== filtered_due[0].red)
                    begin
                        errors++;
                        $display("%0t: red_out expected %h actual %h", $time,
                                 filtered_due[0].red, res.red_out);
                    end
                    if (res.green_out !== filtered_due[0].green)
                    begin
                        errors++;
                        $display("%0t: green_out expected %h actual %h", $time,
                                 filtered_due[0].green, res.green_out);
                    end
                    if (res.blue_out !== filtered_due[0].blue)
                    begin
                        errors++;
                        $display("%0t: blue_out expected %h actual %h", $time,
                                 filtered_due[0].blue, res.blue_out);
                    end
                    if (res.out_column !== filtered_due[0].column)
                    begin
                        errors++;
                        $display("%0t: out_column expected %0d actual %0d", $time,
                                 filtered_due[0].column, res.out_column);
                    end
                    if (res.row_end !== filtered_due[0].row_end)
                    begin
                        errors++;
                        $display("%0t: row_end expected %b actual %b", $time,
                                 filtered_due[0].row_end, res.row_end);
                    end
                    void'(filtered_due.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val[9:0];
            CFG_IMAGE_HEIGHT: img_h = val[9:0];
            CFG_KERNEL_SIZE:  ksize = val[1:0];
            CFG_CENTER_X:     anchor_x = val[1:0];
            CFG_CENTER_Y:     anchor_y = val[1:0];
            CFG_KROW_ZERO:    krow[0] = val;
            CFG_KROW_ONE:     krow[1] = val;
            default:          krow[2] = val;
        endcase
    endtask

    task automatic write_setting(int w, int h, int k, int cx, int cy,
                                 logic [23:0] k0, logic [23:0] k1, logic [23:0] k2);
        write_reg(CFG_IMAGE_WIDTH, 24'(w));
        write_reg(CFG_IMAGE_HEIGHT, 24'(h));
        write_reg(CFG_KERNEL_SIZE, 24'(k));
        write_reg(CFG_CENTER_X, 24'(cx));
        write_reg(CFG_CENTER_Y, 24'(cy));
        write_reg(CFG_KROW_ZERO, k0);
        write_reg(CFG_KROW_ONE, k1);
        write_reg(CFG_KROW_TWO, k2);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_word(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_words.push_back('{op, r, g, b});
        words_queued++;
    endtask

    task automatic queue_random_row(int n, bit op);
        for (int i = 0; i < n; i++)
        begin
            queue_word(op, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Wait until every word is taken and every result has come, then let the unit go idle.
    task automatic wait_quiet();
        while (words_taken != words_queued || filtered_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [23:0] random_krow(int style);
        logic [23:0] r;
        if (style == 0)
        begin
            r = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
        end
        else
        begin
            r = 24'($urandom);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- test sequence

    initial
    begin
        int w;
        int h;
        int k;
        int random_words;
        int style;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.op = 1'b0;
        pix.red_in = '0;
        pix.green_in = '0;
        pix.blue_in = '0;
        res.ready = 1'b1;
        errors = 0;
        words_queued = 0;
        words_taken = 0;
        results_seen = 0;
        settings_used = 0;
        burst_left = 1;
        gap_left = 0;
        gaps_on = 0;
        stall_mode = 0;
        stall_left = 0;
        img_w = 10'd352;
        img_h = 10'd288;
        ksize = 2'd3;
        anchor_x = 2'd1;
        anchor_y = 2'd1;
        for (int i = 0; i < 3; i++)
        begin
            krow[i] = 24'd65793;
            for (int x = 0; x < LINE_MAX; x++)
            begin
                held_rows[i][x] = '0;
            end
        end
        for (int x = 0; x < LINE_MAX; x++)
        begin
            live_row[x] = '0;
        end
        col_count = 0;
        rows_done = 0;
        rows_held = 0;
        next_emit = 0;
        frame_started = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Box kernel on a narrow image: early pad ignored, extreme pixels, bottom pad row.
        write_setting(4, 2, 3, 1, 1, 24'h010101, 24'h010101, 24'h010101);
        queue_word(1'b1, 8'hFF, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'hFF, 8'h00, 8'hFF);
        queue_word(1'b0, 8'h00, 8'hFF, 8'h00);
        queue_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'h00, 8'h00, 8'h00);
        queue_word(1'b1, 8'h12, 8'h34, 8'h56);
        queue_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'h80, 8'h7F, 8'h01);
        queue_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_random_row(4, 1'b1);
        wait_quiet();

        // Signed extremes with a zero divisor, anchor at the far corner.
        write_setting(3, 0, 3, 2, 2, 24'h7F8001, 24'hFF0102, 24'h80FF7F);
        queue_random_row(3, 1'b0);
        queue_word(1'b0, 8'hFF, 8'hFF, 8'hFF);
        queue_word(1'b0, 8'h00, 8'h00, 8'h00);
        queue_word(1'b0, 8'hFF, 8'h00, 8'hFF);
        queue_random_row(3, 1'b1);
        wait_quiet();

        // Single tap, single column; then out-of-range size and width codes.
        write_setting(1, 0, 1, 0, 0, 24'h000002, 24'h000000, 24'h000000);
        queue_random_row(3, 1'b0);
        wait_quiet();
        write_setting(1023, 1023, 0, 3, 3, 24'hFFFFFF, 24'h000000, 24'h000000);
        queue_random_row(3, 1'b0);
        wait_quiet();

        // One long partial row at the largest width fills columns 0 to 269.
        stall_mode = 1;
        gaps_on = 1;
        write_setting(512, 0, 3, 1, 1, 24'h010201, 24'h020402, 24'h010201);
        queue_random_row(270, 1'b0);
        wait_quiet();

        // Random settings, mostly whole rows with random content, some noise.
        random_words = 0;
        while (random_words < 80)
        begin
            stall_mode = $urandom_range(0, 2);
            gaps_on = $urandom_range(0, 1);
            style = $urandom_range(0, 1);
            k = $urandom_range(0, 3);
            w = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 1023)
                                            : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0:       h = rows_done + $urandom_range(1, 2);
                1:       h = 1023;
                default: h = $urandom_range(0, 3);
            endcase
            write_setting(w, h, k, $urandom_range(0, 3), $urandom_range(0, 3),
                          random_krow(style), random_krow(style), random_krow(style));
            if (w == 0 || w == 1023)
            begin
                queue_random_row($urandom_range(3, 10), 1'b0);
                random_words += 10;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    queue_random_row(w, 1'b0);
                    random_words += w;
                end
                repeat ($urandom_range(0, 2))
                begin
                    queue_random_row(w, 1'b1);
                    random_words += w;
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    for (int i = 0; i < $urandom_range(1, 4); i++)
                    begin
                        queue_word($urandom_range(0, 1), 8'($urandom), 8'($urandom),
                                   8'($urandom));
                        random_words++;
                    end
                end
            end
            wait_quiet();
        end

        if (filtered_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, filtered_due.size());
        end
        $display("Sent %0d pixel words and checked %0d filtered pixels over %0d settings.",
                 words_taken, results_seen, settings_used);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
